// ===== hdl/signed_integer_to_ascii_digits_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SIGNED_INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH
`define SIGNED_INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SIDAU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define SIDAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sidau_pkg.sv =====
`default_nettype none

package sidau_pkg;

   // Width of the formatted number.
   localparam int VALUE_BITS = 32;

   // Digit counts: decimal digits of 2^VALUE_BITS (floor(n*log10(2))+1) and hex digits.
   localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int NIB_COUNT  = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int DIGIT_W    = NIB_COUNT * 4;

   // Counter widths.
   localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
   localparam int LEFT_W    = $clog2(NIB_COUNT + 1);

   // Stream words: value and hex_mode in, one character out.
   localparam int REQ_DATA_W = ((VALUE_BITS + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;
   localparam int CHAR_W     = 7;

   // ASCII codes.
   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_HEX_LETTER = 7'd97;
   localparam logic [CHAR_W-1:0] CHAR_MINUS      = 7'd45;
   localparam logic [CHAR_W-1:0] DEC_RADIX       = 7'd10;
   localparam logic [3:0]        DEC_MAX_DIGIT   = 4'd9;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LEADING,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   // ASCII code of one digit value.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      if (d > DEC_MAX_DIGIT) begin
         c = CHAR_HEX_LETTER + CHAR_W'(d) - DEC_RADIX;
      end else begin
         c = CHAR_ZERO + CHAR_W'(d);
      end
      return c;
   endfunction

   // One correction pass of shift-and-add-3: every BCD digit of 5 or more gets 3 added,
   // so that the following left shift carries correctly into the next digit.
   function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] x);
      logic [DIGIT_W-1:0] y;
      logic [3:0] nib;
      y = x;
      for (int i = 0; i < NIB_COUNT; i++) begin
         nib = x[4*i +: 4];
         if (nib >= 4'd5) begin
            y[4*i +: 4] = nib + 4'd3;
         end
      end
      return y;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/signed_integer_to_ascii_digits_unit.sv =====
`default_nettype none
// Signed integer to ASCII digit string.
// The req channel takes one word per number: the signed value and a hex_mode flag
// (0 decimal, 1 lower-case hex). The rsp channel returns one word per character,
// most significant digit first, with '-' in front of a negative value and tlast
// on the final digit. Zero gives a single '0'.
// Decimal digits come from a shift-and-add-3 unit that takes one value bit per
// cycle until every magnitude bit is in; hex skips it. A scan then drops leading
// zero digits, one digit per cycle, and the characters are then sent back to back
// while rsp_tready is high.
// One number is handled at a time: req_tready is high only while the block is
// idle, that is from the cycle after the final character is taken.
// While rsp_tready is low the current character and tlast are held unchanged.
// Reset returns the sequencer to idle and drops any number in progress.
module signed_integer_to_ascii_digits_unit import sidau_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // req_tdata: value [VALUE_BITS-1:0], hex_mode [VALUE_BITS], zero fill above
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rsp_tdata: character [6:0], zero fill [7]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tlast: last
   output logic                       rsp_tlast
);

   state_type              state_ff, state_in;
   logic [DIGIT_W-1:0]     digits_ff, digits_in;
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [BIT_CNT_W-1:0]   bits_ff, bits_in;
   logic [LEFT_W-1:0]      left_ff, left_in;

   logic [VALUE_BITS-1:0]  raw_value;
   logic                   raw_neg;
   logic [VALUE_BITS-1:0]  raw_mag;
   logic                   hex_mode;
   logic [3:0]             top_digit;
   logic [DIGIT_W-1:0]     adjusted;
   logic [CHAR_W-1:0]      out_char;

   // Input word decode and magnitude; the most negative value wraps to 2^(n-1).
   assign raw_value = req_tdata[VALUE_BITS-1:0];
   assign hex_mode  = req_tdata[VALUE_BITS];
   assign raw_neg   = raw_value[VALUE_BITS-1];
   assign raw_mag   = raw_neg ? (~raw_value + VALUE_BITS'(1)) : raw_value;

   assign top_digit = digits_ff[DIGIT_W-1 -: 4];
   assign adjusted  = bcd_adjust(digits_ff);

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      bits_ff   <= bits_in;
      left_ff   <= left_in;
   end

   // Next state and outputs.
   always_comb begin
      state_in   = state_ff;
      digits_in  = digits_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      bits_in    = bits_ff;
      left_in    = left_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      out_char   = digit_char(top_digit);

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               neg_in  = raw_neg;
               mag_in  = raw_mag;
               bits_in = BIT_CNT_W'(VALUE_BITS);
               left_in = LEFT_W'(NIB_COUNT);
               // Hex digits are the magnitude's own nibbles.
               if (hex_mode) begin
                  digits_in = DIGIT_W'(raw_mag);
                  state_in  = ST_LEADING;
               end else begin
                  digits_in = '0;
                  state_in  = ST_CONVERT;
               end
            end
         end

         ST_CONVERT: begin
            // One magnitude bit enters the BCD register per cycle.
            digits_in = {adjusted[DIGIT_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in    = mag_ff << 1;
            bits_in   = bits_ff - BIT_CNT_W'(1);
            if (bits_ff == BIT_CNT_W'(1)) begin
               state_in = ST_LEADING;
            end
         end

         ST_LEADING: begin
            // Drop leading zeros, keeping at least one digit.
            if (top_digit == 4'd0 && left_ff != LEFT_W'(1)) begin
               digits_in = digits_ff << 4;
               left_in   = left_ff - LEFT_W'(1);
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end

         ST_SIGN: begin
            rsp_tvalid = 1'b1;
            out_char   = CHAR_MINUS;
            if (rsp_tready) begin
               state_in = ST_DIGIT;
            end
         end

         ST_DIGIT: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = (left_ff == LEFT_W'(1));
            if (rsp_tready) begin
               if (left_ff == LEFT_W'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  digits_in = digits_ff << 4;
                  left_in   = left_ff - LEFT_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = {1'b0, out_char};

endmodule

`default_nettype wire

// ===== hdl/sidau_checker.sv =====
`default_nettype none
`include "signed_integer_to_ascii_digits_unit_assert.svh"

// Port-level checks of the converter's sequencing.
module sidau_checker import sidau_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // A new number is never taken while characters are being sent.
   `SIDAU_ASSERT_NOW(a_no_accept_while_sending, rsp_tvalid, !req_tready, "req_tready high while rsp_tvalid")

   // After a number is taken the block is busy in the next cycle.
   `SIDAU_ASSERT_NEXT(a_busy_after_accept, !reset && req_tvalid && req_tready, !req_tready, "req_tready high right after an accepted word")

   // The final character ends the run.
   `SIDAU_ASSERT_NEXT(a_idle_after_last, !reset && rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid, "rsp_tvalid high after the final character")

   // A stalled character is held.
   `SIDAU_ASSERT_NEXT(a_hold_on_stall, !reset && rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp word changed while stalled")

endmodule

bind signed_integer_to_ascii_digits_unit sidau_checker u_sidau_checker (.*);

`default_nettype wire

// ===== sim/tb_signed_integer_to_ascii_digits_unit.sv =====
`timescale 1ns / 1ps

// One expected character word on the rsp channel.
typedef struct {
   bit [6:0] character;
   bit       last;
} digit_char_type;

// Predicts the character words of each accepted number and checks the rsp stream.
class ascii_digit_scoreboard;
   localparam bit [6:0] ASC_ZERO   = 7'd48;
   localparam bit [6:0] ASC_LETTER = 7'd97;
   localparam bit [6:0] ASC_MINUS  = 7'd45;
   localparam int       REPORT_MAX = 10;

   digit_char_type pending_chars[$];
   int             error_count = 0;

   // Count a failure; only the first few are printed.
   function void note_failure(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // Format one accepted number into its expected character words.
   function void note_number(bit [31:0] value, bit hex);
      bit [32:0]      mag;
      bit [32:0]      radix;
      bit [3:0]       nib;
      bit [6:0]       digits[$];
      digit_char_type ch;
      radix = hex ? 33'd16 : 33'd10;
      // Widening to 33 bits before negation keeps the most negative value exact.
      mag = value[31] ? (33'd0 - {1'b1, value}) : {1'b0, value};
      do begin
         nib = 4'(mag % radix);
         digits.push_front((nib > 4'd9) ? (ASC_LETTER + 7'(nib) - 7'd10)
                                        : (ASC_ZERO + 7'(nib)));
         mag = mag / radix;
      end while (mag != 0);
      if (value[31]) begin
         ch.character = ASC_MINUS;
         ch.last      = 1'b0;
         pending_chars.push_back(ch);
      end
      foreach (digits[k]) begin
         ch.character = digits[k];
         ch.last      = (k == digits.size() - 1);
         pending_chars.push_back(ch);
      end
   endfunction

   // Compare one accepted rsp word with the oldest expected character.
   function void check_char(bit [6:0] character, bit last);
      digit_char_type want;
      if (pending_chars.size() == 0) begin
         note_failure($sformatf("unexpected character 0x%02h last %0b", character, last));
         return;
      end
      want = pending_chars.pop_front();
      if (want.character !== character || want.last !== last) begin
         note_failure($sformatf("character expected 0x%02h last %0b, got 0x%02h last %0b",
                                want.character, want.last, character, last));
      end
   endfunction

   function int pending();
      return pending_chars.size();
   endfunction

   // Anything still waiting at the end never arrived.
   function void flush_leftover();
      digit_char_type want;
      while (pending_chars.size() != 0) begin
         want = pending_chars.pop_front();
         note_failure($sformatf("missing character 0x%02h last %0b",
                                want.character, want.last));
      end
   endfunction
endclass

module tb_signed_integer_to_ascii_digits_unit;
   import sidau_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_NUMBERS = 47;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 80;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   ascii_digit_scoreboard sb = new;

   int idle_pct     = 0;
   int stall_pct    = 0;
   int numbers_sent = 0;
   bit hold_rsp     = 1'b0;

   signed_integer_to_ascii_digits_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Offer one number word, with random idle cycles ahead of it, and wait for acceptance.
   task automatic send_number(input bit [31:0] value, input bit hex);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({hex, value});
      do @(posedge clock); while (!req_tready);
      sb.note_number(value, hex);
      numbers_sent++;
   endtask

   // Receiver: random stalls, or a solid hold-off while hold_rsp is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
      end
   end

   // Long receiver hold-off while the sender keeps offering numbers.
   initial begin
      wait (numbers_sent >= 30);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Check every rsp word taken.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_char(rsp_tdata[CHAR_W-1:0], rsp_tlast);
      end
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      // Bit 32 selects hex; the low 32 bits are the value.
      bit [32:0] directed_words [21] = '{
         {1'b0, 32'h0000_0000}, {1'b1, 32'h0000_0000}, {1'b0, 32'h0000_0001},
         {1'b0, 32'hffff_ffff}, {1'b1, 32'hffff_ffff}, {1'b0, 32'h0000_0009},
         {1'b0, 32'h0000_000a}, {1'b0, 32'hffff_fff6}, {1'b1, 32'h0000_000f},
         {1'b1, 32'h0000_0010}, {1'b0, 32'h7fff_ffff}, {1'b1, 32'h7fff_ffff},
         {1'b0, 32'h8000_0000}, {1'b1, 32'h8000_0000}, {1'b0, 32'h8000_0001},
         {1'b0, 32'h3b9a_ca00}, {1'b0, 32'hc465_3601}, {1'b1, 32'hdead_beef},
         {1'b1, 32'h00ab_cdef}, {1'b0, 32'h4996_02d2}, {1'b1, 32'hfedc_ba98}
      };
      int        idle_by_phase  [4] = '{0, 70, 0, 20};
      int        stall_by_phase [4] = '{0, 0, 70, 20};
      bit [31:0] value;

      do @(posedge clock); while (reset);

      // Directed numbers: zero, sign boundaries, most negative value, all hex letters.
      foreach (directed_words[i]) begin
         send_number(directed_words[i][31:0], directed_words[i][32]);
      end

      // Random numbers in phases of sender idling and receiver stalling.
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_by_phase[p];
         stall_pct = stall_by_phase[p];
         repeat (PHASE_NUMBERS) begin
            // Mix full-range words with short magnitudes of either sign.
            case ($urandom_range(3))
               0: value = $urandom;
               1: value = $urandom >> $urandom_range(31);
               2: value = 32'd0 - ($urandom >> $urandom_range(31));
               default: value = 32'($urandom_range(20)) - 32'd10;
            endcase
            send_number(value, 1'($urandom_range(1)));
         end
      end
      req_tvalid <= 1'b0;

      // Drain the remaining characters, then give the block time to misbehave.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.flush_leftover();
      if (sb.error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
